### rtl/bfsp_pkg.sv
// Shared types, constants and helpers for the Bellman-Ford shortest path unit.
// No dependencies; used by every module in rtl/.
`default_nettype none

package bfsp_pkg;

	localparam int MAX_NODES   = 64;
	localparam int MAX_EDGES   = 256;
	localparam int WEIGHT_BITS = 32;
	localparam int DIST_BITS   = 48;
	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int NCOUNT_W    = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;

	localparam logic [DIST_BITS-1:0] DIST_HI = {1'b0, {(DIST_BITS-1){1'b1}}};
	localparam logic [DIST_BITS-1:0] DIST_LO = {1'b1, {(DIST_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NODE_COUNT  = 2'd0,
		REG_SOURCE_NODE = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_RELAX,
		S_NEG,
		S_RD,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]                     mode;
		logic [5:0]                     edge_from;
		logic [5:0]                     edge_to;
		logic signed [WEIGHT_BITS-1:0]  edge_weight;
	} item_t;

	typedef struct packed {
		logic [5:0]                     node_index;
		logic signed [DIST_BITS-1:0]    distance;
		logic                           reachable;
		logic                           negative_cycle;
		logic                           last;
	} result_t;

	typedef struct packed {
		logic [NODE_W-1:0]      tail;
		logic [NODE_W-1:0]      head;
		logic [WEIGHT_BITS-1:0] weight;
	} edge_t;

	typedef struct packed {
		logic                 reached;
		logic [DIST_BITS-1:0] path_len;
	} dist_entry_t;

	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] addr;
		dist_entry_t       data;
	} dist_wr_t;

	// 0 acts as 1, anything above the node limit acts as the limit
	function automatic logic [NCOUNT_W-1:0] nodes_in_use(input logic [NCOUNT_W-1:0] c);
		if (c == '0) begin
			return NCOUNT_W'(1);
		end else if (c > NCOUNT_W'(MAX_NODES)) begin
			return NCOUNT_W'(MAX_NODES);
		end else begin
			return c;
		end
	endfunction

endpackage

`default_nettype wire

### rtl/bfsp_edge_store.sv
// Edge list memory: one write port, one registered read port.
// Depends on bfsp_pkg (edge_t).
`default_nettype none

module bfsp_edge_store #(
	parameter int MAX_EDGES = bfsp_pkg::MAX_EDGES
) (
	input  wire logic                                            clk,
	input  wire logic                                            wr_en,
	input  wire logic [$clog2((MAX_EDGES > 1) ? MAX_EDGES : 2)-1:0] wr_addr,
	input  wire bfsp_pkg::edge_t                                 wr_data,
	input  wire logic                                            rd_en,
	input  wire logic [$clog2((MAX_EDGES > 1) ? MAX_EDGES : 2)-1:0] rd_addr,
	output      bfsp_pkg::edge_t                                 rd_data
);

	bfsp_pkg::edge_t mem [MAX_EDGES];
	bfsp_pkg::edge_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/bfsp_dist_store.sv
// Distance memory: one write port, two registered read ports, read-first.
// Depends on bfsp_pkg (dist_entry_t, dist_wr_t).
`default_nettype none

module bfsp_dist_store (
	input  wire logic                          clk,
	input  wire bfsp_pkg::dist_wr_t            wr,
	input  wire logic                          rd_en,
	input  wire logic [bfsp_pkg::NODE_W-1:0]   rd_addr_a,
	input  wire logic [bfsp_pkg::NODE_W-1:0]   rd_addr_b,
	output      bfsp_pkg::dist_entry_t         rd_data_a,
	output      bfsp_pkg::dist_entry_t         rd_data_b
);

	bfsp_pkg::dist_entry_t mem [bfsp_pkg::MAX_NODES];
	bfsp_pkg::dist_entry_t rd_a_q;
	bfsp_pkg::dist_entry_t rd_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

`default_nettype wire

### rtl/bfsp_relax_unit.sv
// Edge relaxation: forwards the previous write, adds weight, saturates, compares.
// Depends on bfsp_pkg; drives the write port of bfsp_dist_store.
`default_nettype none

module bfsp_relax_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               valid,
	input  wire logic [bfsp_pkg::NODE_W-1:0]        tail,
	input  wire logic [bfsp_pkg::NODE_W-1:0]        head,
	input  wire logic signed [bfsp_pkg::WEIGHT_BITS-1:0] weight,
	input  wire logic [bfsp_pkg::NCOUNT_W-1:0]      n,
	input  wire bfsp_pkg::dist_entry_t              rd_tail,
	input  wire bfsp_pkg::dist_entry_t              rd_head,
	output      bfsp_pkg::dist_wr_t                 wr
);

	localparam int DW = bfsp_pkg::DIST_BITS;

	logic                              fwd_v_q;
	logic [bfsp_pkg::NODE_W-1:0]       fwd_addr_q;
	bfsp_pkg::dist_entry_t             fwd_data_q;

	bfsp_pkg::dist_entry_t             t_ent;
	bfsp_pkg::dist_entry_t             h_ent;
	logic signed [DW:0]                sum;
	logic [DW-1:0]                     cand;
	logic                              in_range;
	logic                              upd;

	// last cycle's write is not yet visible in the registered read data
	always_comb begin
		t_ent = (fwd_v_q && fwd_addr_q == tail) ? fwd_data_q : rd_tail;
		h_ent = (fwd_v_q && fwd_addr_q == head) ? fwd_data_q : rd_head;
		sum   = (DW+1)'($signed(t_ent.path_len)) + (DW+1)'(weight);
		if (sum[DW] != sum[DW-1]) begin
			cand = sum[DW] ? bfsp_pkg::DIST_LO : bfsp_pkg::DIST_HI;
		end else begin
			cand = sum[DW-1:0];
		end
		in_range = ({1'b0, tail} < n) && ({1'b0, head} < n);
		upd = valid && in_range && t_ent.reached &&
			(!h_ent.reached || ($signed(h_ent.path_len) > $signed(cand)));
		wr.en            = upd;
		wr.addr          = head;
		wr.data.reached  = 1'b1;
		wr.data.path_len = cand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= wr.en;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= wr.addr;
		fwd_data_q <= wr.data;
	end

endmodule

`default_nettype wire

### rtl/shortest_path_bellman_ford_unit.sv
// Bellman-Ford single-source shortest path unit: edge store, distance store,
// relaxation pipeline and run sequencer. Depends on bfsp_pkg and all bfsp_* modules.
//
// A run with n nodes in use first initializes the distance memory node by node,
// then makes P passes over the stored edges, with P at most n, then reports each
// node in turn (or one negative-cycle result), as the result side allows. In a
// pass, one edge is relaxed per cycle as a read-modify-write through the distance
// memory's two read ports and one write port, with the previous write forwarded.
// No new item is taken until a run has emitted its last result into the output
// register; configuration is always ready.
`default_nettype none

module shortest_path_bellman_ford_unit #(
	parameter int MAX_EDGES = bfsp_pkg::MAX_EDGES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output      logic                                item_stall,
	input  wire bfsp_pkg::item_t                     item,
	output      logic                                result_valid,
	input  wire logic                                result_stall,
	output      bfsp_pkg::result_t                   result,
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [bfsp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bfsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(MAX_EDGES + 1);
	localparam int IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int NW    = bfsp_pkg::NODE_W;
	localparam int NCW   = bfsp_pkg::NCOUNT_W;

	bfsp_pkg::state_t          state_q, state_d;
	logic [NCW-1:0]            node_count_q;
	logic [NCW-1:0]            n_q;
	logic [NW-1:0]             src_q;
	logic [NW-1:0]             node_q;
	logic [NW-1:0]             pass_q;
	logic [CNT_W-1:0]          edge_cnt_q;
	logic [CNT_W-1:0]          k_q;
	logic                      changed_q;
	logic                      v_s1;
	logic                      v_s2;
	logic [NW-1:0]             tail_s2;
	logic [NW-1:0]             head_s2;
	logic [bfsp_pkg::WEIGHT_BITS-1:0] weight_s2;
	bfsp_pkg::result_t         result_q;
	logic                      result_valid_q;

	logic                      item_acc;
	logic                      load_go;
	logic                      run_go;
	logic                      clear_go;
	logic                      out_free;
	logic                      last_node;
	logic                      last_pass;
	logic                      pass_done;
	logic                      edge_issue;
	logic                      dist_rd_en;
	logic [NW-1:0]             dist_addr_a;
	logic [NW-1:0]             dist_addr_b;
	logic                      res_load_neg;
	logic                      res_load_node;

	bfsp_pkg::edge_t           edge_wr_data;
	bfsp_pkg::edge_t           edge_rd;
	bfsp_pkg::dist_wr_t        dist_wr;
	bfsp_pkg::dist_wr_t        relax_wr;
	bfsp_pkg::dist_entry_t     rd_a;
	bfsp_pkg::dist_entry_t     rd_b;

	assign cfg_ready    = 1'b1;
	assign result       = result_q;
	assign result_valid = result_valid_q;

	assign item_acc  = item_valid && !item_stall;
	assign load_go   = item_acc && item.mode == bfsp_pkg::MODE_LOAD &&
		edge_cnt_q < CNT_W'(MAX_EDGES);
	assign run_go    = item_acc && item.mode == bfsp_pkg::MODE_RUN;
	assign clear_go  = item_acc && item.mode == bfsp_pkg::MODE_CLEAR;
	assign out_free  = !result_valid_q || !result_stall;
	assign last_node = ({1'b0, node_q} == n_q - NCW'(1));
	assign last_pass = ({1'b0, pass_q} == n_q - NCW'(1));
	assign pass_done = (k_q == edge_cnt_q) && !v_s1 && !v_s2;

	assign edge_wr_data.tail   = item.edge_from;
	assign edge_wr_data.head   = item.edge_to;
	assign edge_wr_data.weight = item.edge_weight;

	bfsp_edge_store #(
		.MAX_EDGES (MAX_EDGES)
	) u_edges (
		.clk     (clk),
		.wr_en   (load_go),
		.wr_addr (edge_cnt_q[IDX_W-1:0]),
		.wr_data (edge_wr_data),
		.rd_en   (edge_issue),
		.rd_addr (k_q[IDX_W-1:0]),
		.rd_data (edge_rd)
	);

	bfsp_dist_store u_dist (
		.clk       (clk),
		.wr        (dist_wr),
		.rd_en     (dist_rd_en),
		.rd_addr_a (dist_addr_a),
		.rd_addr_b (dist_addr_b),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	bfsp_relax_unit u_relax (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (v_s2),
		.tail    (tail_s2),
		.head    (head_s2),
		.weight  ($signed(weight_s2)),
		.n       (n_q),
		.rd_tail (rd_a),
		.rd_head (rd_b),
		.wr      (relax_wr)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfsp_pkg::S_IDLE: begin
				if (run_go) state_d = bfsp_pkg::S_INIT;
			end
			bfsp_pkg::S_INIT: begin
				if (last_node) state_d = bfsp_pkg::S_RELAX;
			end
			bfsp_pkg::S_RELAX: begin
				if (pass_done) begin
					if (!changed_q) begin
						state_d = bfsp_pkg::S_RD;
					end else if (last_pass) begin
						state_d = bfsp_pkg::S_NEG;
					end
				end
			end
			bfsp_pkg::S_NEG: begin
				if (out_free) state_d = bfsp_pkg::S_IDLE;
			end
			bfsp_pkg::S_RD: begin
				state_d = bfsp_pkg::S_EMIT;
			end
			bfsp_pkg::S_EMIT: begin
				if (out_free) state_d = last_node ? bfsp_pkg::S_IDLE : bfsp_pkg::S_RD;
			end
			default: state_d = bfsp_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_stall    = (state_q != bfsp_pkg::S_IDLE);
		edge_issue    = (state_q == bfsp_pkg::S_RELAX) && (k_q < edge_cnt_q);
		dist_rd_en    = v_s1 || (state_q == bfsp_pkg::S_RD);
		dist_addr_a   = (state_q == bfsp_pkg::S_RD) ? node_q : edge_rd.tail;
		dist_addr_b   = edge_rd.head;
		res_load_neg  = (state_q == bfsp_pkg::S_NEG) && out_free;
		res_load_node = (state_q == bfsp_pkg::S_EMIT) && out_free;
		if (state_q == bfsp_pkg::S_INIT) begin
			dist_wr.en            = 1'b1;
			dist_wr.addr          = node_q;
			dist_wr.data.reached  = (node_q == src_q);
			dist_wr.data.path_len = '0;
		end else begin
			dist_wr = relax_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bfsp_pkg::S_IDLE;
			node_count_q   <= NCW'(bfsp_pkg::MAX_NODES);
			src_q          <= '0;
			n_q            <= NCW'(1);
			node_q         <= '0;
			pass_q         <= '0;
			edge_cnt_q     <= '0;
			k_q            <= '0;
			changed_q      <= 1'b0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= edge_issue;
			v_s2    <= v_s1;

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bfsp_pkg::REG_NODE_COUNT) begin
					node_count_q <= cfg_data[NCW-1:0];
				end else if (cfg_index == bfsp_pkg::REG_SOURCE_NODE) begin
					src_q <= cfg_data[NW-1:0];
				end
			end

			if (load_go) begin
				edge_cnt_q <= edge_cnt_q + CNT_W'(1);
			end else if (clear_go) begin
				edge_cnt_q <= '0;
			end

			if (run_go) begin
				n_q    <= bfsp_pkg::nodes_in_use(node_count_q);
				node_q <= '0;
			end

			if (state_q == bfsp_pkg::S_INIT) begin
				if (last_node) begin
					node_q    <= '0;
					pass_q    <= '0;
					k_q       <= '0;
					changed_q <= 1'b0;
				end else begin
					node_q <= node_q + NW'(1);
				end
			end

			if (state_q == bfsp_pkg::S_RELAX) begin
				if (edge_issue) k_q <= k_q + CNT_W'(1);
				if (relax_wr.en) changed_q <= 1'b1;
				if (pass_done && changed_q && !last_pass) begin
					pass_q    <= pass_q + NW'(1);
					k_q       <= '0;
					changed_q <= 1'b0;
				end
			end

			if (res_load_node && !last_node) begin
				node_q <= node_q + NW'(1);
			end

			if (res_load_neg || res_load_node) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tail_s2   <= edge_rd.tail;
		head_s2   <= edge_rd.head;
		weight_s2 <= edge_rd.weight;
		if (res_load_neg) begin
			result_q.node_index     <= '0;
			result_q.distance       <= '0;
			result_q.reachable      <= 1'b0;
			result_q.negative_cycle <= 1'b1;
			result_q.last           <= 1'b1;
		end else if (res_load_node) begin
			result_q.node_index     <= node_q;
			result_q.distance       <= rd_a.reached ? $signed(rd_a.path_len) : '0;
			result_q.reachable      <= rd_a.reached;
			result_q.negative_cycle <= 1'b0;
			result_q.last           <= last_node;
		end
	end

	a_edge_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		edge_cnt_q <= CNT_W'(MAX_EDGES))
		else $error("edge count past store depth");

	a_dist_wr: assert property (@(posedge clk) disable iff (!arst_n)
		dist_wr.en |-> (state_q == bfsp_pkg::S_INIT || state_q == bfsp_pkg::S_RELAX))
		else $error("distance write outside init or relaxation");

	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> state_q == bfsp_pkg::S_RELAX)
		else $error("relaxation pipeline busy outside a pass");

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bfsp_pkg::S_RELAX |-> ({1'b0, pass_q} < n_q))
		else $error("pass counter past node count");

	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.negative_cycle) |-> (result.last && !result.reachable))
		else $error("negative-cycle transaction malformed");

endmodule

`default_nettype wire

### test/tb_shortest_path_bellman_ford_unit.sv
`timescale 1ns / 100ps
// Testbench for shortest_path_bellman_ford_unit: loads edges, clears and runs the unit under
// random valid/stall gaps and checks each result against a built-in path predictor.
// Depends on bfsp_pkg and the RTL in rtl/.

module tb_shortest_path_bellman_ford_unit;
	import bfsp_pkg::*;

	localparam logic [1:0]           MODE_IGNORED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
	localparam longint               DIST_MAX     = (longint'(1) <<< (DIST_BITS - 1)) - 1;
	localparam longint               DIST_MIN     = -(longint'(1) <<< (DIST_BITS - 1));

	class path_scoreboard;
		logic [5:0] tails[MAX_EDGES];
		logic [5:0] heads[MAX_EDGES];
		longint     weights[MAX_EDGES];
		int         edges_held;
		logic [6:0] node_count_reg;
		logic [5:0] source_reg;
		result_t    expected_results[$];
		int         mismatches;

		function new();
			edges_held = 0;
			node_count_reg = 7'(MAX_NODES);
			source_reg = '0;
			mismatches = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == REG_NODE_COUNT) begin
				node_count_reg = data;
			end else if (index == REG_SOURCE_NODE) begin
				source_reg = data[5:0];
			end
		endfunction

		function void note_item(item_t it);
			case (it.mode)
				MODE_LOAD: begin
					if (edges_held < MAX_EDGES) begin
						tails[edges_held] = it.edge_from;
						heads[edges_held] = it.edge_to;
						weights[edges_held] = longint'(signed'(it.edge_weight));
						edges_held++;
					end
				end
				MODE_CLEAR: begin
					edges_held = 0;
				end
				MODE_RUN: begin
					shortest_paths();
				end
				default: begin
				end
			endcase
		endfunction

		// tails visited in ascending order, each tail's edges in load order
		function void shortest_paths();
			longint  best[MAX_NODES];
			bit      reached[MAX_NODES];
			int      order[$];
			int      n;
			int      k;
			int      t;
			int      h;
			longint  cand;
			bit      changed;
			bit      negative;
			result_t r;

			if (node_count_reg == 0) begin
				n = 1;
			end else if (node_count_reg > MAX_NODES) begin
				n = MAX_NODES;
			end else begin
				n = int'(node_count_reg);
			end
			for (int i = 0; i < n; i++) begin
				best[i] = 0;
				reached[i] = 1'b0;
			end
			if (source_reg < n) begin
				reached[source_reg] = 1'b1;
			end
			for (int j = 0; j < n; j++) begin
				for (int e = 0; e < edges_held; e++) begin
					if (tails[e] == j && heads[e] < n) begin
						order = {order, e};
					end
				end
			end
			negative = 1'b0;
			for (int p = 0; p < n; p++) begin
				changed = 1'b0;
				for (int x = 0; x < order.size(); x++) begin
					k = order[x];
					t = tails[k];
					h = heads[k];
					if (reached[t]) begin
						cand = best[t] + weights[k];
						if (cand > DIST_MAX) begin
							cand = DIST_MAX;
						end
						if (cand < DIST_MIN) begin
							cand = DIST_MIN;
						end
						if (!reached[h] || best[h] > cand) begin
							best[h] = cand;
							reached[h] = 1'b1;
							changed = 1'b1;
						end
					end
				end
				if (!changed) begin
					break;
				end
				if (p == n - 1) begin
					negative = 1'b1;
				end
			end
			if (negative) begin
				r = '0;
				r.negative_cycle = 1'b1;
				r.last = 1'b1;
				expected_results = {expected_results, r};
			end else begin
				for (int i = 0; i < n; i++) begin
					r.node_index = 6'(i);
					r.distance = reached[i] ? best[i][DIST_BITS-1:0] : '0;
					r.reachable = reached[i];
					r.negative_cycle = 1'b0;
					r.last = (i == n - 1);
					expected_results = {expected_results, r};
				end
			end
		endfunction

		function string describe(result_t r);
			return $sformatf("node %0d distance %0d reachable %0b negative_cycle %0b last %0b",
				r.node_index, $signed(r.distance), r.reachable, r.negative_cycle, r.last);
		endfunction

		function void check_result(result_t got);
			result_t want;

			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: %s", describe(got));
				end
				return;
			end
			want = expected_results.pop_front();
			if (got.node_index !== want.node_index || got.distance !== want.distance
					|| got.reachable !== want.reachable
					|| got.negative_cycle !== want.negative_cycle || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result mismatch: expected %s", describe(want));
					$display("                 actual   %s", describe(got));
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	item_t                 item = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	bit                    tx_quiet = 1'b0;
	bit                    rx_quiet = 1'b0;
	int                    stall_left = 0;
	int                    random_sent = 0;
	path_scoreboard        board;

	shortest_path_bellman_ford_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(200_000_000);
		$display("shortest_path_bellman_ford_unit verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				board.check_result(result);
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_stall <= 1'b1;
			end else if (rx_quiet || $urandom_range(0, 99) < 70) begin
				result_stall <= 1'b0;
			end else begin
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(0, 2);
				result_stall <= 1'b1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (tx_quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [5:0] random_node(int span);
		if ($urandom_range(0, 9) == 0) begin
			return 6'($urandom_range(0, 63));
		end
		return 6'($urandom_range(0, span - 1));
	endfunction

	function automatic logic [WEIGHT_BITS-1:0] random_weight(bit with_negatives);
		if ($urandom_range(0, 19) == 0) begin
			return $urandom;
		end else if (with_negatives) begin
			return 32'(int'($urandom_range(0, 130)) - 30);
		end
		return 32'($urandom_range(0, 100));
	endfunction

	// leaves valid high on return; the caller sends again or settles in the same step
	task automatic send_item(logic [1:0] mode, logic [5:0] from_node, logic [5:0] to_node,
			logic [WEIGHT_BITS-1:0] weight);
		item_t next;
		int    gap;
		next.mode = mode;
		next.edge_from = from_node;
		next.edge_to = to_node;
		next.edge_weight = weight;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= next;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		board.note_item(next);
	endtask

	task automatic settle();
		if (item_valid) begin
			item_valid <= 1'b0;
		end
		while (board.expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		cfg_index <= index;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.set_register(index, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_batch(int span);
		int edges;
		bit with_negatives;
		if ($urandom_range(0, 9) != 0) begin
			send_item(MODE_CLEAR, 6'($urandom), 6'($urandom), $urandom);
			random_sent++;
		end
		edges = $urandom_range(1, 16);
		with_negatives = $urandom_range(0, 1);
		repeat (edges) begin
			if ($urandom_range(0, 15) == 0) begin
				send_item(MODE_IGNORED, 6'($urandom), 6'($urandom), $urandom);
			end
			send_item(MODE_LOAD, random_node(span), random_node(span),
				random_weight(with_negatives));
			random_sent++;
		end
		send_item(MODE_RUN, 6'($urandom), 6'($urandom), $urandom);
		random_sent++;
	endtask

	initial begin
		int count_cfg;
		int span;
		int src;

		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: 64 nodes, source 0
		send_item(MODE_RUN, 6'd0, 6'd0, 32'd0);
		send_item(MODE_LOAD, 6'd0, 6'd1, 32'h7FFF_FFFF);
		send_item(MODE_LOAD, 6'd1, 6'd2, 32'h8000_0000);
		send_item(MODE_LOAD, 6'd0, 6'd63, 32'hFFFF_FFFF);
		send_item(MODE_LOAD, 6'd63, 6'd62, 32'd5);
		send_item(MODE_IGNORED, 6'd63, 6'd63, 32'hFFFF_FFFF);
		send_item(MODE_RUN, 6'd63, 6'd63, 32'hFFFF_FFFF);
		send_item(MODE_LOAD, 6'd2, 6'd3, -32'sd7);
		send_item(MODE_LOAD, 6'd3, 6'd2, 32'd3);
		send_item(MODE_RUN, 6'd0, 6'd0, 32'd0);
		send_item(MODE_CLEAR, 6'd0, 6'd0, 32'd0);
		send_item(MODE_RUN, 6'd0, 6'd0, 32'd0);
		settle();

		// node count 0 acts as a single node
		write_register(REG_UNUSED, 7'h7F);
		write_register(REG_NODE_COUNT, 7'd0);
		write_register(REG_SOURCE_NODE, 7'h40);
		send_item(MODE_LOAD, 6'd0, 6'd0, 32'hFFFF_FFFF);
		send_item(MODE_RUN, 6'd0, 6'd0, 32'd0);
		send_item(MODE_CLEAR, 6'd0, 6'd0, 32'd0);
		send_item(MODE_LOAD, 6'd0, 6'd0, 32'd5);
		send_item(MODE_RUN, 6'd0, 6'd0, 32'd0);
		settle();

		// count above the limit, source 63
		write_register(REG_NODE_COUNT, 7'h7F);
		write_register(REG_SOURCE_NODE, 7'h7F);
		send_item(MODE_LOAD, 6'd63, 6'd0, 32'd2);
		send_item(MODE_LOAD, 6'd0, 6'd5, -32'sd3);
		send_item(MODE_RUN, 6'd0, 6'd0, 32'd0);
		settle();

		// source outside the nodes in use, then edges outside them
		write_register(REG_NODE_COUNT, 7'd4);
		write_register(REG_SOURCE_NODE, 7'd10);
		send_item(MODE_RUN, 6'd0, 6'd0, 32'd0);
		settle();
		write_register(REG_SOURCE_NODE, 7'd0);
		send_item(MODE_RUN, 6'd0, 6'd0, 32'd0);

		while (random_sent < 70) begin
			settle();
			case ($urandom_range(0, 9))
				0: count_cfg = 0;
				1: count_cfg = 1;
				2: count_cfg = MAX_NODES;
				3: count_cfg = $urandom_range(MAX_NODES + 1, 127);
				default: count_cfg = $urandom_range(2, MAX_NODES - 1);
			endcase
			span = (count_cfg == 0) ? 1 : (count_cfg > MAX_NODES) ? MAX_NODES : count_cfg;
			src = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, span - 1);
			write_register(REG_NODE_COUNT, 7'(count_cfg));
			write_register(REG_SOURCE_NODE, 7'($urandom_range(0, 1) * 64 + src));
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet <= ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3)) begin
				random_batch(span);
				if ($urandom_range(0, 4) == 0) begin
					settle();
				end
			end
		end

		settle();
		repeat (16) @(posedge clk);

		if (board.mismatches == 0 && board.expected_results.size() == 0) begin
			$display("shortest_path_bellman_ford_unit verification clean");
		end else begin
			$display("shortest_path_bellman_ford_unit verification failed");
		end
		$finish;
	end

endmodule
